[design/qrs_pkg.sv]
// shared types and constants for the quadratic root solver
// no dependencies
`default_nettype none
package qrs_pkg;
  typedef enum logic [1:0] {
    ST_TWO   = 2'd0,
    ST_ONE   = 2'd1,
    ST_NONE  = 2'd2,
    ST_AZERO = 2'd3
  } status_t;

  localparam int ROOT_WIDTH = 34;
endpackage
`default_nettype wire

[design/qrs_sqrt_cell.sv]
// one restoring square-root step: brings down one bit pair, decides one root bit
// depends on qrs_pkg; carries the coefficient payload alongside
`default_nettype none
module qrs_sqrt_cell
  import qrs_pkg::*;
#(
  parameter int DW = 32,
  parameter int RW = 24,
  parameter int NW = 34,
  parameter int AW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [DW-1:0]        in_disc,
  input  wire logic [RW+1:0]        in_rem,
  input  wire logic [RW-1:0]        in_root,
  input  wire logic signed [NW-1:0] in_nb,
  input  wire logic signed [AW-1:0] in_a,
  input  wire status_t              in_status,
  input  wire logic                 stall,
  output logic                      out_valid,
  output logic [DW-1:0]             out_disc,
  output logic [RW+1:0]             out_rem,
  output logic [RW-1:0]             out_root,
  output logic signed [NW-1:0]      out_nb,
  output logic signed [AW-1:0]      out_a,
  output status_t                   out_status
);
  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          take;

  always_comb begin
    rem_sh = {in_rem[RW-1:0], in_disc[DW-1 -: 2]};
    trial  = {in_root, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall) begin
      out_valid <= in_valid;
    end
    if (!stall) begin
      out_disc   <= {in_disc[DW-3:0], 2'b00};
      out_rem    <= take ? (rem_sh - trial) : rem_sh;
      out_root   <= {in_root[RW-2:0], take};
      out_nb     <= in_nb;
      out_a      <= in_a;
      out_status <= in_status;
    end
  end
endmodule
`default_nettype wire

[design/qrs_div_cell.sv]
// one restoring division step on magnitudes for both roots at once
// depends on qrs_pkg
`default_nettype none
module qrs_div_cell
  import qrs_pkg::*;
#(
  parameter int QW = 48,
  parameter int DVW = 17
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [QW-1:0]  in_qp,
  input  wire logic [QW-1:0]  in_qm,
  input  wire logic [DVW:0]   in_rp,
  input  wire logic [DVW:0]   in_rm,
  input  wire logic [DVW-1:0] in_den,
  input  wire logic [1:0]     in_neg,
  input  wire status_t        in_status,
  input  wire logic           stall,
  output logic                out_valid,
  output logic [QW-1:0]       out_qp,
  output logic [QW-1:0]       out_qm,
  output logic [DVW:0]        out_rp,
  output logic [DVW:0]        out_rm,
  output logic [DVW-1:0]      out_den,
  output logic [1:0]          out_neg,
  output status_t             out_status
);
  logic [DVW:0] sp, sm;
  logic         tp, tm;

  always_comb begin
    sp = {in_rp[DVW-1:0], in_qp[QW-1]};
    sm = {in_rm[DVW-1:0], in_qm[QW-1]};
    tp = (sp >= {1'b0, in_den});
    tm = (sm >= {1'b0, in_den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall) begin
      out_valid <= in_valid;
    end
    if (!stall) begin
      out_rp     <= tp ? (sp - {1'b0, in_den}) : sp;
      out_rm     <= tm ? (sm - {1'b0, in_den}) : sm;
      out_qp     <= {in_qp[QW-2:0], tp};
      out_qm     <= {in_qm[QW-2:0], tm};
      out_den    <= in_den;
      out_neg    <= in_neg;
      out_status <= in_status;
    end
  end
endmodule
`default_nettype wire

[design/quadratic_root_solver_top.sv]
// quadratic root solver: discriminant stages, square-root cell chain, divider cell chain
// depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell
//
//  channel | signals                          | direction
//  in      | in_valid in_stall coef_a/b/c     | request in
//  out     | out_valid out_stall root_plus/   | result out
//          | root_minus status                |
//
// one request per cycle unless a held result freezes the pipe; pipeline: 2 product/discriminant stages
// + (COEF_WIDTH+1+FRAC_BITS) sqrt cells + 1 numerator stage
// + (COEF_WIDTH+FRAC_BITS+3) div cells + 1 output stage
// every cell moves one request per cycle while the pipe is not frozen
// rst is synchronous and empties the pipe; a held result freezes the whole pipe,
// in_stall is that same freeze, so an empty output never stalls the input
`default_nettype none
module quadratic_root_solver_top
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COEF_WIDTH-1:0] coef_a,
  input  wire logic signed [COEF_WIDTH-1:0] coef_b,
  input  wire logic signed [COEF_WIDTH-1:0] coef_c,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [ROOT_WIDTH-1:0]      root_plus,
  output logic signed [ROOT_WIDTH-1:0]      root_minus,
  output status_t                           status
);
  localparam int CW  = COEF_WIDTH;
  localparam int PW  = 2 * CW + 2;          // product / discriminant width, signed
  localparam int DWH = (PW + 1) / 2;        // bit pairs of the discriminant
  localparam int DW  = 2 * DWH;
  localparam int NS  = DWH + FRAC_BITS;     // sqrt steps
  localparam int RW  = NS;                  // root width
  localparam int NW  = CW + FRAC_BITS + 2;  // -b*2^F width, signed
  localparam int QW  = (NW > RW ? NW : RW) + 1; // numerator magnitude width
  localparam int DVW = CW + 1;              // |2a|

  logic stall;
  assign stall    = out_valid & out_stall;
  assign in_stall = stall;

  // stage 1: products
  logic                  s1_valid;
  logic signed [PW-1:0]  s1_bb, s1_ac;
  logic signed [CW-1:0]  s1_a, s1_b;
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (!stall) s1_valid <= in_valid;
    if (!stall) begin
      s1_bb <= PW'(coef_b * coef_b);
      s1_ac <= PW'(coef_a * coef_c);
      s1_a  <= coef_a;
      s1_b  <= coef_b;
    end
  end

  // stage 2: discriminant and class
  logic                 s2_valid;
  logic signed [PW-1:0] disc;
  logic [DW-1:0]        s2_disc;
  logic signed [NW-1:0] s2_nb;
  logic signed [CW-1:0] s2_a;
  status_t              s2_status;
  assign disc = s1_bb - (s1_ac <<< 2);
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (!stall) s2_valid <= s1_valid;
    if (!stall) begin
      s2_disc <= disc[PW-1] ? '0 : DW'(unsigned'(disc));
      s2_nb   <= -(NW'(s1_b) <<< FRAC_BITS);
      s2_a    <= s1_a;
      if (s1_a == '0)        s2_status <= ST_AZERO;
      else if (disc[PW-1])   s2_status <= ST_NONE;
      else if (disc == '0)   s2_status <= ST_ONE;
      else                   s2_status <= ST_TWO;
    end
  end

  // square-root chain
  logic                 sv   [NS+1];
  logic [DW-1:0]        sd   [NS+1];
  logic [RW+1:0]        srem [NS+1];
  logic [RW-1:0]        sr   [NS+1];
  logic signed [NW-1:0] snb  [NS+1];
  logic signed [CW-1:0] sa   [NS+1];
  status_t              sst  [NS+1];
  assign sv[0] = s2_valid;  assign sd[0] = s2_disc; assign srem[0] = '0;
  assign sr[0] = '0;        assign snb[0] = s2_nb;  assign sa[0] = s2_a;
  assign sst[0] = s2_status;
  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    qrs_sqrt_cell #(.DW(DW), .RW(RW), .NW(NW), .AW(CW)) u_cell (
      .clk, .rst, .stall,
      .in_valid(sv[i]), .in_disc(sd[i]), .in_rem(srem[i]), .in_root(sr[i]),
      .in_nb(snb[i]), .in_a(sa[i]), .in_status(sst[i]),
      .out_valid(sv[i+1]), .out_disc(sd[i+1]), .out_rem(srem[i+1]),
      .out_root(sr[i+1]), .out_nb(snb[i+1]), .out_a(sa[i+1]), .out_status(sst[i+1])
    );
  end

  // numerators, signs and divisor
  logic                    s3_valid;
  logic [QW-1:0]           s3_qp, s3_qm;
  logic [DVW-1:0]          s3_den;
  logic [1:0]              s3_neg;
  status_t                 s3_status;
  logic signed [QW:0]      np, nm, sroot, nbx;
  logic signed [DVW-1:0]   den_s;
  logic [DVW-1:0]          den_mag;
  always_comb begin
    sroot   = (sst[NS] == ST_TWO) ? (QW+1)'(sr[NS]) : '0;
    nbx     = (QW+1)'(snb[NS]);
    np      = nbx + sroot;
    nm      = nbx - sroot;
    den_s   = DVW'(sa[NS]) <<< 1;
    den_mag = den_s[DVW-1] ? DVW'(-den_s) : DVW'(den_s);
  end
  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (!stall) s3_valid <= sv[NS];
    if (!stall) begin
      s3_qp     <= np[QW] ? QW'(-np) : QW'(np);
      s3_qm     <= nm[QW] ? QW'(-nm) : QW'(nm);
      s3_den    <= (den_mag == '0) ? DVW'(1) : den_mag;
      s3_neg    <= {np[QW] ^ den_s[DVW-1], nm[QW] ^ den_s[DVW-1]};
      s3_status <= sst[NS];
    end
  end

  // divider chain
  logic           dv  [QW+1];
  logic [QW-1:0]  dqp [QW+1];
  logic [QW-1:0]  dqm [QW+1];
  logic [DVW:0]   drp [QW+1];
  logic [DVW:0]   drm [QW+1];
  logic [DVW-1:0] dd  [QW+1];
  logic [1:0]     dn  [QW+1];
  status_t        dst [QW+1];
  assign dv[0] = s3_valid; assign dqp[0] = s3_qp; assign dqm[0] = s3_qm;
  assign drp[0] = '0;      assign drm[0] = '0;    assign dd[0] = s3_den;
  assign dn[0] = s3_neg;   assign dst[0] = s3_status;
  for (genvar j = 0; j < QW; j++) begin : g_div
    qrs_div_cell #(.QW(QW), .DVW(DVW)) u_cell (
      .clk, .rst, .stall,
      .in_valid(dv[j]), .in_qp(dqp[j]), .in_qm(dqm[j]), .in_rp(drp[j]),
      .in_rm(drm[j]), .in_den(dd[j]), .in_neg(dn[j]), .in_status(dst[j]),
      .out_valid(dv[j+1]), .out_qp(dqp[j+1]), .out_qm(dqm[j+1]),
      .out_rp(drp[j+1]), .out_rm(drm[j+1]), .out_den(dd[j+1]),
      .out_neg(dn[j+1]), .out_status(dst[j+1])
    );
  end

  // output register with sign restore; both roots zeroed when there are no roots or a == 0
  logic [QW-1:0] qp_s, qm_s;
  logic          zero_out;
  always_comb begin
    qp_s     = dn[QW][1] ? QW'(-dqp[QW]) : dqp[QW];
    qm_s     = dn[QW][0] ? QW'(-dqm[QW]) : dqm[QW];
    zero_out = (dst[QW] == ST_AZERO) || (dst[QW] == ST_NONE);
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!stall) out_valid <= dv[QW];
    if (!stall) begin
      root_plus  <= zero_out ? '0 : ROOT_WIDTH'(qp_s);
      root_minus <= zero_out ? '0 : ROOT_WIDTH'(qm_s);
      status     <= dst[QW];
    end
  end
endmodule
`default_nettype wire

[design/qrs_checker.sv]
// port-level checks for the quadratic root solver
// depends on qrs_pkg; bound to quadratic_root_solver_top
`default_nettype none
module qrs_checker
  import qrs_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [ROOT_WIDTH-1:0] root_plus,
  input wire logic [ROOT_WIDTH-1:0] root_minus,
  input wire status_t               status
);
  a_no_root: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NONE || status == ST_AZERO) |->
      root_plus == '0 && root_minus == '0) else $error("nonzero root without roots");
  a_one_root: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ONE |-> root_plus == root_minus)
    else $error("repeated root differs");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(root_plus) && $stable(status))
    else $error("stalled result changed");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall) else $error("input stalled with empty output");
endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .root_plus, .root_minus, .status
);
`default_nettype wire
